// ----- hdl/lrucpf_pkg.sv -----
// Shared constants and types for the LRU set-associative cache with next-line prefetch.
package lrucpf_pkg;

    localparam int NUM_SETS     = 1024;
    localparam int MAX_WAYS     = 8;
    localparam int LINE_BYTES   = 32;
    localparam int OFFSET_BITS  = $clog2(LINE_BYTES);
    localparam int ADDR_W       = 32;
    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int IDX_BITS_MAX = $clog2(NUM_SETS + 1) - 1;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W       = WAY_W;
    localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
    localparam int TAG_W        = ADDR_W - OFFSET_BITS;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = ((1 + 2 * CNT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 1'b1;

    // One set of the tag store: tags, LRU ages and valid bits of all ways
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
        logic [MAX_WAYS-1:0]             valid;
    } set_row_t;

    localparam int ROW_W = $bits(set_row_t);

    // Outcome of one set lookup
    typedef struct packed {
        logic     hit;
        set_row_t row;
    } lookup_t;

endpackage

// ----- hdl/lru_set_assoc_cache_next_line_prefetch.sv -----
// Top level: LRU set-associative tag cache with next-line prefetch and hit/access counters.
// Flow: once an input word is accepted, the set is read, then updated for the demand line,
//   read and updated for the next line, and the result is loaded into the output register.
// A new address is accepted only in the idle state, after both read-modify-writes on the
//   single-port set memory and the result load for the previous address are done.
// Reset: aresetn (synchronous, active low) clears counters and control, then a clearing
//   pass over all 1024 sets invalidates every set; s_tready stays low during that pass.
module lru_set_assoc_cache_next_line_prefetch (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrucpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrucpf_pkg::CFG_W-1:0]        cfg_data,
    // Address stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrucpf_pkg::S_DATA_W-1:0]     s_tdata,   // [31:0] address
    // Result stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrucpf_pkg::M_DATA_W-1:0]     m_tdata    // [0] hit, [32:1] hit_total,
                                                           // [64:33] access_total, rest zero
);
    import lrucpf_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SET_W-1:0]  clr_cnt_reg;
    logic [ADDR_W-1:0] cur_addr_reg;      // line address under work, demand then next line
    logic              pass_reg;          // low: demand pass, high: prefetch pass
    logic              hit_reg;           // demand hit of the current word
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [CFG_W-1:0]  ways_reg;
    logic [CFG_W-1:0]  bits_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [CNT_W-1:0]  out_hit_cnt_reg;
    logic [CNT_W-1:0]  out_acc_cnt_reg;

    logic [WCNT_W-1:0] eff_ways;
    logic [CFG_W-1:0]  eff_bits;
    logic [TAG_W-1:0]  line_addr;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic              ram_we;
    logic [SET_W-1:0]  ram_addr;
    set_row_t          ram_wdata;
    set_row_t          ram_rdata;
    lookup_t           lk_res;
    logic              in_fire;
    logic              out_load;

    // Clamp the configuration to the ranges the hardware supports
    always_comb begin
        if (ways_reg == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (ways_reg > CFG_W'(MAX_WAYS)) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(ways_reg);
        end
    end

    assign eff_bits = (bits_reg > CFG_W'(IDX_BITS_MAX)) ? CFG_W'(IDX_BITS_MAX) : bits_reg;

    // Split the line address into set index and tag under the current index width
    assign line_addr = cur_addr_reg[ADDR_W-1:OFFSET_BITS];
    assign set_idx   = line_addr[SET_W-1:0] & ~({SET_W{1'b1}} << eff_bits);
    assign tag       = line_addr >> eff_bits;

    // Set memory: swept with zeros after reset, else read then rewritten per pass
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE);
    assign ram_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_idx;
    assign ram_wdata = (state_reg == ST_CLEAR) ? set_row_t'('0) : lk_res.row;

    lrucpf_tag_ram u_tag_ram (
        .aclk    (aclk),
        .we_i    (ram_we),
        .addr_i  (ram_addr),
        .wdata_i (ram_wdata),
        .rdata_o (ram_rdata)
    );

    // One lookup unit serves both the demand and the prefetch pass
    lrucpf_way_unit u_way_unit (
        .row_i  (ram_rdata),
        .tag_i  (tag),
        .ways_i (eff_ways),
        .res_o  (lk_res)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    // Load the result only once the output register is free or being drained
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = pass_reg ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pass_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            ways_reg      <= CFG_W'(1);
            bits_reg      <= CFG_W'(10);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_WAYS_IN_USE:    ways_reg <= cfg_data;
                    REG_SET_INDEX_BITS: bits_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_fire) begin
                pass_reg <= 1'b0;
            end else if (state_reg == ST_UPDATE && !pass_reg) begin
                // Demand pass done: count it, advance to the prefetch pass
                pass_reg    <= 1'b1;
                hit_reg     <= lk_res.hit;
                acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
                if (lk_res.hit) begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cur_addr_reg <= s_tdata;
        end else if (state_reg == ST_UPDATE && !pass_reg) begin
            cur_addr_reg <= cur_addr_reg + ADDR_W'(LINE_BYTES);   // wraps at 32 bits
        end
        if (out_load) begin
            out_hit_reg     <= hit_reg;
            out_hit_cnt_reg <= hit_cnt_reg;
            out_acc_cnt_reg <= acc_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - 1 - 2 * CNT_W)'(0), out_acc_cnt_reg, out_hit_cnt_reg,
                       out_hit_reg};

`ifndef SYNTHESIS
    // No input word while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // Set memory is written only by the clearing pass or an update step
    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_UPDATE)))
        else $error("set memory written outside clear or update");

    // Hit counter moves by exactly the demand hit
    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && !pass_reg) |=>
            (hit_cnt_reg == $past(hit_cnt_reg) + CNT_W'($past(lk_res.hit))))
        else $error("hit counter out of step with demand lookup");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");
`endif

endmodule

// ----- hdl/lrucpf_tag_ram.sv -----
// Single-port set memory holding tags, LRU ages and valid bits, registered read.
module lrucpf_tag_ram (
    input  logic                        aclk,
    input  logic                        we_i,
    input  logic [lrucpf_pkg::SET_W-1:0] addr_i,
    input  lrucpf_pkg::set_row_t        wdata_i,
    output lrucpf_pkg::set_row_t        rdata_o
);
    import lrucpf_pkg::*;

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[addr_i] <= wdata_i;
        end
        rdata_reg <= mem[addr_i];
    end

    assign rdata_o = set_row_t'(rdata_reg);

endmodule

// ----- hdl/lrucpf_way_unit.sv -----
// Shared lookup and LRU update unit: compares one tag against a set and builds the new set.
module lrucpf_way_unit (
    input  lrucpf_pkg::set_row_t              row_i,
    input  logic [lrucpf_pkg::TAG_W-1:0]      tag_i,
    input  logic [lrucpf_pkg::WCNT_W-1:0]     ways_i,
    output lrucpf_pkg::lookup_t               res_o
);
    import lrucpf_pkg::*;

    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic                have_free;
    logic [WCNT_W-1:0]   count;
    logic [RANK_W-1:0]   oldest;
    logic [WAY_W-1:0]    victim;
    logic                fill;
    logic [WAY_W-1:0]    touch_way;
    logic [RANK_W-1:0]   old_rank;
    set_row_t            nrow;

    // Scan the ways: match, occupancy, lowest free way, last way holding the oldest age
    always_comb begin
        match     = '0;
        hit_way   = '0;
        free_way  = '0;
        have_free = 1'b0;
        count     = '0;
        oldest    = '0;
        victim    = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            match[i] = row_i.valid[i] && (row_i.tag[i] == tag_i);
            if (row_i.valid[i]) begin
                count = count + WCNT_W'(1);
                if (row_i.rank[i] >= oldest) begin
                    oldest = row_i.rank[i];
                    victim = WAY_W'(i);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_way  = WAY_W'(i);
            end
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WAY_W'(i);
            end
        end
    end

    assign hit       = |match;
    assign fill      = !hit && have_free && (count < ways_i);
    assign touch_way = hit ? hit_way : victim;
    assign old_rank  = row_i.rank[touch_way];

    always_comb begin
        nrow = row_i;
        if (fill) begin
            // Age every resident line, place the new one as most recent
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (row_i.valid[i]) begin
                    nrow.rank[i] = row_i.rank[i] + RANK_W'(1);
                end
            end
            nrow.valid[free_way] = 1'b1;
            nrow.tag[free_way]   = tag_i;
            nrow.rank[free_way]  = '0;
        end else begin
            // Hit or eviction: promote one way, age the younger ones
            if (!hit) begin
                nrow.tag[victim] = tag_i;
            end
            for (int i = 0; i < MAX_WAYS; i++) begin
                if ((WAY_W'(i) != touch_way) && row_i.valid[i] &&
                    (row_i.rank[i] < old_rank)) begin
                    nrow.rank[i] = row_i.rank[i] + RANK_W'(1);
                end
            end
            nrow.rank[touch_way] = '0;
        end
    end

    assign res_o.hit = hit;
    assign res_o.row = nrow;

endmodule
